// ===== rtl/sdfcs_pkg.sv =====
// Package: shared constants, types and fixed-point helpers for the SDF coverage shaper.
package sdfcs_pkg;

	localparam int FRAC_BITS = 15;
	localparam int DW        = 16;              // field width
	localparam int QW        = FRAC_BITS + 2;   // holds 0..ONE and a little more
	localparam int NW        = 18;              // signed ramp numerator/denominator width
	localparam int DIV_STEPS = FRAC_BITS;       // quotient bits per ramp position
	localparam logic [QW-1:0] ONE_Q  = QW'(1) << FRAC_BITS;
	localparam logic [2*QW:0] HALF_P = (2*QW+1)'(1) << (FRAC_BITS - 1);

	localparam logic [1:0] MODE_SMOOTH   = 2'd0;
	localparam logic [1:0] MODE_SMOOTHER = 2'd1;
	localparam logic [1:0] MODE_SLAB     = 2'd2;
	localparam logic [1:0] MODE_GLOW     = 2'd3;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_CENTRE = 3'd1;
	localparam logic [2:0] REG_HALF   = 3'd2;
	localparam logic [2:0] REG_INNER  = 3'd3;
	localparam logic [2:0] REG_OUTER  = 3'd4;
	localparam logic [2:0] REG_AA     = 3'd5;
	localparam logic [2:0] REG_GLOW   = 3'd6;

	// ramp division progress for one of two ramps
	typedef struct packed {
		logic [NW-1:0] rem;     // partial remainder
		logic [NW-1:0] den;     // divisor
		logic [QW-1:0] quo;     // quotient so far
		logic          fixed;   // result already known
		logic [QW-1:0] fix_val; // known result
	} ramp_t;

	// configuration as seen by the pipeline
	typedef struct packed {
		logic [1:0]    mode;
		logic [DW-1:0] centre;
		logic [14:0]   half;
		logic [DW-1:0] inner;
		logic [DW-1:0] outer;
		logic [DW-1:0] aa;
		logic [DW-1:0] glow;
	} cfg_t;

	// fixed-point product rounded half up, inputs in [0, ONE]
	function automatic logic [QW-1:0] mul_q(input logic [QW-1:0] a, input logic [QW-1:0] b);
		logic [2*QW:0] p;
		p = (2*QW+1)'(a) * (2*QW+1)'(b) + HALF_P;
		return QW'(p >> FRAC_BITS);
	endfunction

endpackage

// ===== rtl/sdf_coverage_shaper.sv =====
// Top level: SDF coverage shaper with configuration registers and ramp setup.
//   channel   | handshake          | payload
//   in        | in_valid/in_ready  | sample[15:0]
//   out       | out_valid/out_ready| coverage[15:0]
//   config    | cfg_we             | cfg_index[2:0], cfg_data[15:0]
// One transaction per cycle while the output is not stalled; the pipeline is setup,
// 15 divider stages (one ramp quotient bit per stage), 4 shaping stages, output register.
// Reset clears all valid bits and loads the register reset values.
// The whole pipeline stalls together while the output register holds a
// transaction that is not taken; a bubble in the output lets it advance.
module sdf_coverage_shaper import sdfcs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [DW-1:0] sample,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [DW-1:0] coverage,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [DW-1:0] cfg_data
);

	cfg_t  cfg_q;
	logic  adv;
	logic  setup_vld_s1;
	ramp_t ra_s1, rb_s1;
	logic [1:0] mode_s1;
	logic  dv;
	logic [QW-1:0] dta, dtb;
	logic [1:0] dmode;
	logic  sv;
	logic [DW-1:0] scov;
	logic [DW-1:0] cov_q;
	logic  ovld_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= MODE_SMOOTH;
			cfg_q.centre <= 16'd16384;
			cfg_q.half   <= 15'd2048;
			cfg_q.inner  <= 16'd16384;
			cfg_q.outer  <= 16'd8192;
			cfg_q.aa     <= 16'd1024;
			cfg_q.glow   <= 16'd8192;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   cfg_q.mode   <= cfg_data[1:0];
				REG_CENTRE: cfg_q.centre <= cfg_data;
				REG_HALF:   cfg_q.half   <= cfg_data[14:0];
				REG_INNER:  cfg_q.inner  <= cfg_data;
				REG_OUTER:  cfg_q.outer  <= cfg_data;
				REG_AA:     cfg_q.aa     <= cfg_data;
				REG_GLOW:   cfg_q.glow   <= cfg_data;
				default:    ;
			endcase
		end
	end

	// advance whenever the output slot is free or being drained
	assign adv      = !ovld_q || out_ready;
	assign in_ready = adv;

	// ramp setup: decide trivial cases, load divider for the rest
	function automatic ramp_t ramp_init(input logic signed [NW-1:0] lo,
		input logic signed [NW-1:0] hi, input logic signed [NW-1:0] v);
		ramp_t r;
		logic signed [NW-1:0] num, den;
		num       = v - lo;
		den       = hi - lo;
		r.rem     = '0;
		r.quo     = '0;
		r.fixed   = 1'b1;
		r.fix_val = '0;
		r.den     = den;
		if (den == 0) begin
			r.fix_val = (v >= lo) ? ONE_Q : '0;
		end else if (num <= 0) begin
			r.fix_val = '0;
		end else if (num >= den) begin
			r.fix_val = ONE_Q;
		end else begin
			r.fixed = 1'b0;
			r.rem   = num;
		end
		return r;
	endfunction

	logic signed [NW-1:0] s_x, c_x, k_x, ie_x, oe_x, aa_x, gw_x, glo_x;
	logic signed [NW-1:0] alo, ahi, blo, bhi;

	always_comb begin
		s_x   = $signed({2'b0, sample});
		c_x   = $signed({2'b0, cfg_q.centre});
		k_x   = $signed({3'b0, cfg_q.half});
		ie_x  = $signed({2'b0, cfg_q.inner});
		oe_x  = $signed({2'b0, cfg_q.outer});
		aa_x  = $signed({2'b0, cfg_q.aa});
		gw_x  = $signed({2'b0, cfg_q.glow});
		glo_x = ie_x - gw_x;
		if (glo_x < 0) glo_x = '0;
		else if (glo_x > $signed({1'b0, ONE_Q})) glo_x = $signed({1'b0, ONE_Q});
		case (cfg_q.mode)
			MODE_SMOOTH, MODE_SMOOTHER: begin
				alo = c_x - k_x;
				ahi = c_x + k_x;
			end
			MODE_SLAB: begin
				alo = oe_x;
				ahi = oe_x + aa_x;
			end
			default: begin
				alo = glo_x;
				ahi = ie_x;
			end
		endcase
		blo = ie_x - aa_x;
		bhi = ie_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_vld_s1 <= 1'b0;
		end else if (adv) begin
			setup_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ra_s1   <= ramp_init(alo, ahi, s_x);
			rb_s1   <= ramp_init(blo, bhi, s_x);
			mode_s1 <= cfg_q.mode;
		end
	end

	sdfcs_ramp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (setup_vld_s1),
		.in_a     (ra_s1),
		.in_b     (rb_s1),
		.in_mode  (mode_s1),
		.out_vld  (dv),
		.out_ta   (dta),
		.out_tb   (dtb),
		.out_mode (dmode)
	);

	sdfcs_shape u_shape (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (dv),
		.ta      (dta),
		.tb      (dtb),
		.mode    (dmode),
		.out_vld (sv),
		.out_cov (scov)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (adv) begin
			ovld_q <= sv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) cov_q <= scov;
	end

	assign out_valid = ovld_q;
	assign coverage  = cov_q;

`ifndef NO_ASSERTIONS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(coverage)))
		else $error("output transaction dropped during stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid) |-> in_ready) else $error("stalled with empty output");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> coverage <= DW'(ONE_Q)) else $error("coverage out of range");
`endif

endmodule

// ===== rtl/sdfcs_ramp_div.sv =====
// Pipelined restoring divider: one ramp position quotient bit per stage for two ramps.
module sdfcs_ramp_div import sdfcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_vld,
	input  ramp_t                in_a,
	input  ramp_t                in_b,
	input  logic [1:0]           in_mode,
	output logic                 out_vld,
	output logic [QW-1:0]        out_ta,
	output logic [QW-1:0]        out_tb,
	output logic [1:0]           out_mode
);

	ramp_t      a_s [DIV_STEPS+1];
	ramp_t      b_s [DIV_STEPS+1];
	logic [1:0] m_s [DIV_STEPS+1];
	logic [DIV_STEPS:0] v_s;

	assign a_s[0] = in_a;
	assign b_s[0] = in_b;
	assign m_s[0] = in_mode;
	assign v_s[0] = in_vld;

	// one shift-subtract step
	function automatic ramp_t div_step(input ramp_t r);
		ramp_t         o;
		logic [NW-1:0] sh;
		o  = r;
		sh = r.rem << 1;
		if (sh >= r.den) begin
			o.rem = sh - r.den;
			o.quo = {r.quo[QW-2:0], 1'b1};
		end else begin
			o.rem = sh;
			o.quo = {r.quo[QW-2:0], 1'b0};
		end
		return o;
	endfunction

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (adv) begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				a_s[g+1] <= div_step(a_s[g]);
				b_s[g+1] <= div_step(b_s[g]);
				m_s[g+1] <= m_s[g];
			end
		end
	end

	assign out_vld  = v_s[DIV_STEPS];
	assign out_mode = m_s[DIV_STEPS];
	assign out_ta   = a_s[DIV_STEPS].fixed ? a_s[DIV_STEPS].fix_val : a_s[DIV_STEPS].quo;
	assign out_tb   = b_s[DIV_STEPS].fixed ? b_s[DIV_STEPS].fix_val : b_s[DIV_STEPS].quo;

endmodule

// ===== rtl/sdfcs_shape.sv =====
// Polynomial shaping pipeline: smoothstep, smootherstep, slab product and saturation.
module sdfcs_shape import sdfcs_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_vld,
	input  logic [QW-1:0]  ta,
	input  logic [QW-1:0]  tb,
	input  logic [1:0]     mode,
	output logic           out_vld,
	output logic [DW-1:0]  out_cov
);

	localparam int PW = QW + 4;  // signed polynomial width
	localparam int XW = QW + PW + 1;  // quintic product width

	// stage 1: squares
	logic [QW-1:0] ta_s1, tb_s1, ta2_s1, tb2_s1;
	logic [1:0]    mode_s1;
	// stage 2: cubic and quintic factors, t^3
	logic [QW-1:0] ta2_s2, tb2_s2, ta3_s2, pa_s2, pb_s2;
	logic [PW-1:0] pq_s2;
	logic [1:0]    mode_s2;
	// stage 3: shaped values
	logic [QW-1:0] sa_s3, sb_s3;
	logic [1:0]    mode_s3;
	// stage 4: result
	logic [QW-1:0] r_s4;
	logic [4:1]    v_q;

	logic signed [PW-1:0] quint_c, cub_a, cub_b;
	logic [QW-1:0] sat_qa, sat_qb, sa_c, sb_c, down_c, r_c;

	// cubic factor 3 - 2t and quintic factor 6t^2 - 15t + 10
	always_comb begin
		cub_a   = PW'(3 * $signed({4'd0, ONE_Q}) - 2 * $signed({4'd0, ta_s1}));
		cub_b   = PW'(3 * $signed({4'd0, ONE_Q}) - 2 * $signed({4'd0, tb_s1}));
		quint_c = PW'(6 * $signed({4'd0, ta2_s1}) - 15 * $signed({4'd0, ta_s1})
			+ 10 * $signed({4'd0, ONE_Q}));
		sat_qa  = (mode_s1 == MODE_SMOOTHER) ?
			((quint_c < 0) ? '0 : (quint_c > $signed({4'd0, ONE_Q}) ? ONE_Q :
			QW'(quint_c))) : QW'(cub_a);
		sat_qb  = QW'(cub_b);
	end

	// saturate shaped values and combine for the slab
	function automatic logic [QW-1:0] sat1(input logic [QW-1:0] x);
		return (x > ONE_Q) ? ONE_Q : x;
	endfunction

	// t^3 times the wide quintic factor, rounded half up and saturated to ONE
	function automatic logic [QW-1:0] mul_quint(input logic [QW-1:0] a,
		input logic [PW-1:0] b);
		logic [XW-1:0] p;
		p = XW'(a) * XW'(b) + XW'(HALF_P);
		p = p >> FRAC_BITS;
		return (p > XW'(ONE_Q)) ? ONE_Q : QW'(p);
	endfunction

	always_comb begin
		sa_c   = (mode_s2 == MODE_SMOOTHER) ? mul_quint(ta3_s2, pq_s2)
			: sat1(mul_q(ta2_s2, pa_s2));
		sb_c   = sat1(mul_q(tb2_s2, pb_s2));
		down_c = ONE_Q - sb_s3;
		r_c    = (mode_s3 == MODE_SLAB) ? sat1(mul_q(sa_s3, down_c)) : sa_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[3:1], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ta_s1   <= ta;
			tb_s1   <= tb;
			ta2_s1  <= mul_q(ta, ta);
			tb2_s1  <= mul_q(tb, tb);
			mode_s1 <= mode;
			ta2_s2  <= ta2_s1;
			tb2_s2  <= tb2_s1;
			ta3_s2  <= mul_q(ta2_s1, ta_s1);
			// quintic factor may exceed ONE, hold it unclipped up to 10*ONE
			pq_s2   <= (quint_c < 0) ? '0 : $unsigned(quint_c);
			pa_s2   <= sat_qa;
			pb_s2   <= sat_qb;
			mode_s2 <= mode_s1;
			sa_s3   <= sa_c;
			sb_s3   <= sb_c;
			mode_s3 <= mode_s2;
			r_s4    <= r_c;
		end
	end

	assign out_vld = v_q[4];
	assign out_cov = DW'(r_s4);

`ifndef NO_ASSERTIONS
	a_cov_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> out_cov <= DW'(ONE_Q)) else $error("coverage above one");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_q)) else $error("valid moved during stall");
	a_slab_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[3] && mode_s3 == MODE_SLAB) |-> r_c <= sa_s3) else $error("slab grew");
`endif

endmodule
